>>> sv/ffcba_pkg.sv
package ffcba_pkg;

  // Disk geometry and the map layout: one RAM word holds the bits of WORD_W blocks.
  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 1;
  localparam int RES_CLAMP       = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_BLOCKS;
  localparam int WORD_W          = 32;
  localparam int NUM_ROWS        = NUM_BLOCKS / WORD_W;
  localparam int ROW_W           = $clog2(NUM_ROWS);
  localparam int BIT_W           = $clog2(WORD_W);
  localparam int BLK_W           = ROW_W + BIT_W;

  // Field widths of the transaction payloads.
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int FIRST_W = 10;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIRST_W-1:0] first_block;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_step;
    logic       fill_rel;
    logic       fill_alloc;
    logic       fill_wr;
    logic       rsp_load;
    logic [1:0] rsp_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic len_bad;
    logic range_bad;
    logic count_zero;
    logic hit;
    logic last_row;
    logic fill_last;
  } dp_sts_t;

  // Contents of a map row right after reset: the reserved blocks are marked used.
  function automatic logic [WORD_W-1:0] reset_row(logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int j = 0; j < WORD_W; j++) begin
      w[j] = (int'({row, BIT_W'(j)}) < RES_CLAMP);
    end
    return w;
  endfunction

endpackage

>>> sv/ffcba_ram.sv
module ffcba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/ffcba_dp.sv
module ffcba_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffcba_pkg::dp_cmd_t cmd_i,
  input  ffcba_pkg::req_t   req_i,
  output ffcba_pkg::dp_sts_t sts_o,
  output ffcba_pkg::rsp_t   rsp_o
);
  import ffcba_pkg::*;

  req_t               req_q;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   rd_row_q;
  logic [COUNT_W-1:0] run_q;
  logic [NUM_ROWS-1:0] valid_q;
  logic [ROW_W-1:0]   fill_row_q;
  logic [BLK_W-1:0]   fill_lo_q;
  logic [BLK_W-1:0]   fill_hi_q;
  logic               fill_val_q;
  rsp_t               rsp_q;

  logic [ROW_W-1:0]   raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  fill_mask;
  logic [COUNT_W-1:0] len;
  logic [COUNT_W:0]   rel_end;
  logic [WORD_W-1:0]  hit_vec;
  logic [WORD_W-1:0]  lmask;
  logic [BIT_W-1:0]   hit_idx;
  logic [BIT_W-1:0]   occ_msb;
  logic [BLK_W-1:0]   end_blk;
  logic [BLK_W-1:0]   head_blk;
  logic [COUNT_W-1:0] run_d;

  assign len     = req_q.run_length;
  assign rel_end = (COUNT_W+1)'(req_q.start_block) + (COUNT_W+1)'(len);

  // A row never written since reset still holds its reset contents.
  assign word = valid_q[rd_row_q] ? ram_rdata : reset_row(rd_row_q);

  always_comb begin
    if (cmd_i.scan_start) begin
      raddr = '0;
    end else if (cmd_i.scan_step) begin
      raddr = row_q + ROW_W'(1);
    end else begin
      raddr = fill_row_q;
    end
  end

  // Run detection: bit j completes a run when the len blocks ending at j are free,
  // counting the run carried in from earlier rows when len reaches past bit 0.
  always_comb begin
    hit_vec = '0;
    lmask   = '0;
    hit_idx = '0;
    occ_msb = '0;
    for (int j = 0; j < WORD_W; j++) begin
      for (int k = 0; k < WORD_W; k++) begin
        lmask[k] = (k <= j);
      end
      if (len > COUNT_W'(j + 1)) begin
        hit_vec[j] = ((word & lmask) == '0) &&
                     (({1'b0, run_q} + (COUNT_W+1)'(j + 1)) >= {1'b0, len});
      end else begin
        hit_vec[j] = ((word & lmask & ~(lmask >> len[BIT_W:0])) == '0);
      end
    end
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = BIT_W'(j);
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (word[j]) begin
        occ_msb = BIT_W'(j);
      end
    end
  end

  assign end_blk  = {row_q, hit_idx};
  assign head_blk = BLK_W'(COUNT_W'(end_blk) + COUNT_W'(1) - len);
  assign run_d    = (|word) ? (COUNT_W'(WORD_W - 1) - COUNT_W'(occ_msb))
                            : (run_q + COUNT_W'(WORD_W));

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      fill_mask[j] = ({fill_row_q, BIT_W'(j)} >= fill_lo_q) &&
                     ({fill_row_q, BIT_W'(j)} <= fill_hi_q);
    end
  end

  assign wdata = (word & ~fill_mask) | (fill_val_q ? fill_mask : '0);

  ffcba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (cmd_i.fill_wr),
    .waddr_i(fill_row_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.fill_wr) begin
      valid_q[fill_row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= raddr;
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_start) begin
      row_q <= '0;
      run_q <= '0;
    end else if (cmd_i.scan_step) begin
      row_q <= row_q + ROW_W'(1);
      run_q <= run_d;
    end
    if (cmd_i.fill_rel) begin
      fill_lo_q  <= BLK_W'(req_q.start_block);
      fill_hi_q  <= BLK_W'(rel_end - (COUNT_W+1)'(1));
      fill_row_q <= req_q.start_block[START_W-1:BIT_W];
      fill_val_q <= 1'b0;
    end else if (cmd_i.fill_alloc) begin
      fill_lo_q  <= head_blk;
      fill_hi_q  <= end_blk;
      fill_row_q <= head_blk[BLK_W-1:BIT_W];
      fill_val_q <= 1'b1;
    end else if (cmd_i.fill_wr) begin
      fill_row_q <= fill_row_q + ROW_W'(1);
    end
    if (cmd_i.rsp_load) begin
      rsp_q.status      <= cmd_i.rsp_status;
      rsp_q.first_block <= cmd_i.fill_alloc ? FIRST_W'(head_blk) : '0;
    end
  end

  assign sts_o.is_release = (req_q.cmd == CMD_RELEASE);
  assign sts_o.len_bad    = (len == '0) || (len > COUNT_W'(NUM_BLOCKS));
  assign sts_o.range_bad  = (rel_end > (COUNT_W+1)'(NUM_BLOCKS));
  assign sts_o.count_zero = (len == '0);
  assign sts_o.hit        = |hit_vec;
  assign sts_o.last_row   = (row_q == ROW_W'(NUM_ROWS - 1));
  assign sts_o.fill_last  = (fill_row_q == fill_hi_q[BLK_W-1:BIT_W]);

  assign rsp_o = rsp_q;

endmodule

>>> sv/ffcba_ctrl.sv
module ffcba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               rsp_valid_o,
  input  ffcba_pkg::dp_sts_t sts_i,
  output ffcba_pkg::dp_cmd_t cmd_o
);
  import ffcba_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_FILL_RD = 3'd3;
  localparam logic [2:0] S_FILL_WR = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_release) begin
          if (sts_i.range_bad) begin
            cmd_o.rsp_load   = 1'b1;
            cmd_o.rsp_status = STATUS_RANGE;
            state_d          = S_RESP;
          end else if (sts_i.count_zero) begin
            cmd_o.rsp_load   = 1'b1;
            cmd_o.rsp_status = STATUS_DONE;
            state_d          = S_RESP;
          end else begin
            cmd_o.fill_rel   = 1'b1;
            cmd_o.rsp_load   = 1'b1;
            cmd_o.rsp_status = STATUS_DONE;
            state_d          = S_FILL_RD;
          end
        end else if (sts_i.len_bad) begin
          cmd_o.rsp_load   = 1'b1;
          cmd_o.rsp_status = STATUS_NOFIT;
          state_d          = S_RESP;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.fill_alloc = 1'b1;
          cmd_o.rsp_load   = 1'b1;
          cmd_o.rsp_status = STATUS_DONE;
          state_d          = S_FILL_RD;
        end else if (sts_i.last_row) begin
          cmd_o.rsp_load   = 1'b1;
          cmd_o.rsp_status = STATUS_NOFIT;
          state_d          = S_RESP;
        end
      end
      S_FILL_RD: begin
        state_d = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = sts_i.fill_last ? S_RESP : S_FILL_RD;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);

endmodule

>>> sv/first_fit_contiguous_block_allocator.sv
// Sequence: a rejected or zero-length request goes from decode straight to the result strobe;
// an allocate decodes, scans up to 32 map rows of 32 blocks one by one, then rewrites each row
// the run touches with a read and a write before the strobe; a release skips the scan.
// Throughput: one transaction at a time; the map RAM port (one row read per cycle) sets
// the scan rate. A new request is taken the cycle after the result strobe.
// Reset clears the controller at once; per-row valid bits stand in for a clearing pass.
module first_fit_contiguous_block_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ffcba_pkg::req_t req_i,
  output logic            rsp_valid_o,
  output ffcba_pkg::rsp_t rsp_o
);
  import ffcba_pkg::*;

  // The controller sequences each transaction; the datapath owns the occupancy map
  // (a RAM of 32-bit rows), the scan counters and the result register.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  ffcba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .rsp_valid_o(rsp_valid_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // The scan checks one row per cycle. It carries the length of the free run that
  // ends at the top of the previous row, so a run may span any number of rows.
  // Once a run is found, or a release is decoded, the affected rows are rewritten
  // one by one with a read-modify-write.
  ffcba_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (dp_cmd),
    .req_i (req_i),
    .sts_o (dp_sts),
    .rsp_o (rsp_o)
  );

  // A result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe held for more than one cycle");

  // An accepted transaction makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The result is given while the transaction still holds the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy)
    else $error("result strobe outside a transaction");

  // A failed request never reports a block number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != STATUS_DONE)) |-> (rsp_o.first_block == '0))
    else $error("failed request returned a nonzero first block");

  // Only the defined status codes are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ((rsp_o.status == STATUS_DONE) || (rsp_o.status == STATUS_NOFIT) ||
                     (rsp_o.status == STATUS_RANGE)))
    else $error("undefined status code");

endmodule

>>> tb/first_fit_contiguous_block_allocator_tb.sv
module first_fit_contiguous_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffcba_pkg::*;

  // The whole run, from the slowest legal item up, fits well below this many cycles.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_ITEMS = 830;
  localparam int          DRAIN_CYCLES = 200;

  // Scoreboard: keeps its own copy of the occupancy map, works out the response of
  // every accepted request in order, and compares the responses that come back.
  class block_map_scoreboard;
    bit [NUM_BLOCKS-1:0] occupied;
    rsp_t                expected_rsp[$];
    int unsigned         errors;

    function new();
      errors = 0;
      occupied = '0;
      for (int b = 0; b < RES_CLAMP; b++) begin
        occupied[b] = 1'b1;
      end
    endfunction

    // First-fit search from block 0, or a bounds-checked clear of a range.
    function rsp_t predict_response(req_t r);
      rsp_t res;
      int   len;
      int   run;
      int   head;
      bit   found;
      res   = '0;
      len   = int'(r.run_length);
      run   = 0;
      head  = 0;
      found = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
        res.status = STATUS_NOFIT;
        if (len != 0 && len <= NUM_BLOCKS) begin
          for (int b = 0; b < NUM_BLOCKS && !found; b++) begin
            if (!occupied[b]) begin
              if (run == 0) head = b;
              run++;
              if (run == len) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (int b = head; b < head + len; b++) occupied[b] = 1'b1;
            res.status      = STATUS_DONE;
            res.first_block = FIRST_W'(head);
          end
        end
      end else begin
        if (int'(r.start_block) + len > NUM_BLOCKS) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int b = int'(r.start_block); b < int'(r.start_block) + len; b++) begin
            occupied[b] = 1'b0;
          end
          res.status = STATUS_DONE;
        end
      end
      return res;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t res;
      res = predict_response(r);
      expected_rsp.push_back(res);
      return res;
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with no request pending: status %0d first_block %0d",
                 $time, got.status, got.first_block);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, got.status);
          errors++;
        end
        if (got.first_block !== want.first_block) begin
          $display("%0t: first_block mismatch: expected %0d, actual %0d",
                   $time, want.first_block, got.first_block);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  block_map_scoreboard sb;
  int unsigned         cycle_count = 0;

  // When set, requests follow each other back to back with no idle cycles.
  bit back_to_back = 1'b0;

  // Runs handed out by the allocator that the stimulus may later give back.
  int live_start[$];
  int live_len[$];

  first_fit_contiguous_block_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // 8 ns clock: 4 ns low, 4 ns high.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A guard against a hang: the run is cut off well past the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Each response is present for exactly one cycle, so it is taken at the rising edge
  // that ends the strobe cycle. Outputs are read before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) sb.check_response(rsp_o);
  end

  // Presents one request at a falling edge and holds it until the rising edge at which
  // busy is low, which is the edge that accepts the transaction. The request is handed
  // to the scoreboard at that edge. The task returns at the next falling edge with start
  // still high, so a back-to-back request does not drop and raise start in one step.
  task automatic send_request(input req_t r, output rsp_t predicted);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = sb.note_request(r);
    @(negedge clk_i);
  endtask

  // Builds a request from plain numbers and tracks every run that the allocator grants.
  task automatic issue(input logic cmd, input int first, input int count);
    req_t r;
    rsp_t predicted;
    r.cmd         = cmd;
    r.start_block = START_W'(first);
    r.run_length  = COUNT_W'(count);
    send_request(r, predicted);
    if (cmd == CMD_ALLOC && predicted.status == STATUS_DONE) begin
      live_start.push_back(int'(predicted.first_block));
      live_len.push_back(count);
    end
  endtask

  initial begin
    int pick;
    int idx;
    int len;
    int first;
    int offs;
    sb     = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Block 0 starts out reserved for the map itself.
    issue(CMD_ALLOC,   0,    0);     // zero-length allocate fails
    issue(CMD_ALLOC,   0,    2047);  // longer than the disk
    issue(CMD_ALLOC,   0,    1024);  // whole disk, but the reserved block is in the way
    issue(CMD_ALLOC,   1023, 1);     // start field is ignored on allocate
    issue(CMD_ALLOC,   0,    1022);  // fills the disk exactly
    issue(CMD_ALLOC,   0,    1);     // disk full
    issue(CMD_RELEASE, 1023, 1);     // last block, in bounds
    issue(CMD_RELEASE, 1023, 2);     // one past the end
    issue(CMD_RELEASE, 0,    0);     // zero-length release
    issue(CMD_RELEASE, 1023, 0);
    issue(CMD_ALLOC,   0,    1);     // only the last block is free
    issue(CMD_RELEASE, 0,    1);     // the reserved block may be released too
    issue(CMD_ALLOC,   0,    1);
    issue(CMD_RELEASE, 0,    1024);  // clear the whole map
    issue(CMD_ALLOC,   0,    1024);  // now the whole disk fits
    issue(CMD_RELEASE, 1,    1024);  // range runs past the end
    issue(CMD_RELEASE, 1023, 2047);  // largest fields
    issue(CMD_RELEASE, 0,    1024);
    issue(CMD_ALLOC,   511,  3);
    issue(CMD_ALLOC,   0,    5);
    issue(CMD_RELEASE, 1,    2);     // a hole too small for the next request
    issue(CMD_ALLOC,   0,    4);
    issue(CMD_ALLOC,   0,    2);     // lands in the hole
    issue(CMD_RELEASE, 0,    1024);
    live_start.delete();
    live_len.delete();

    // Random part: mostly allocations and releases of granted runs, so the map keeps
    // filling and fragmenting; the rest is zero lengths, stray ranges, raw fields and full clears.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 3) back_to_back = !back_to_back;
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 80 && live_start.size() == 0) pick = 0;
      if (pick < 45) begin
        offs = $urandom_range(0, 99);
        if (offs < 80)      len = $urandom_range(1, 32);
        else if (offs < 95) len = $urandom_range(33, 256);
        else                len = $urandom_range(257, 1024);
        issue(CMD_ALLOC, $urandom_range(0, 1023), len);
      end else if (pick < 80) begin
        idx   = $urandom_range(0, live_start.size() - 1);
        first = live_start[idx];
        len   = live_len[idx];
        if ($urandom_range(0, 3) == 0) begin
          // Give back only part of the run; the rest leaves the list and stays used unless a later range covers it.
          offs  = $urandom_range(0, len - 1);
          first = first + offs;
          len   = $urandom_range(1, len - offs);
        end
        issue(CMD_RELEASE, first, len);
        live_start.delete(idx);
        live_len.delete(idx);
      end else if (pick < 85) begin
        issue(1'($urandom_range(0, 1)), $urandom_range(0, 1023), 0);
      end else if (pick < 95) begin
        first = $urandom_range(0, 1023);
        issue(CMD_RELEASE, first, $urandom_range(0, 1024 - first + 4));
      end else if (pick < 98) begin
        issue(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 2047));
      end else begin
        issue(CMD_RELEASE, 0, 1024);
        live_start.delete();
        live_len.delete();
      end
    end
    start <= 1'b0;

    // Let every outstanding response arrive, then watch a while for stray strobes.
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
